// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/fdtd_pkg.sv -----
`timescale 1ns / 1ps
package fdtd_pkg;

    localparam int CELLS_DEF     = 4096;
    localparam int MATERIALS_DEF = 16;
    localparam int NCOEF         = 10;

    // command codes
    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_WRITE  = 1'b1;

    // axis codes
    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    // material kinds (code 3 behaves as plain)
    localparam logic [1:0] KIND_PLAIN = 2'd0;
    localparam logic [1:0] KIND_DRUDE = 2'd1;
    localparam logic [1:0] KIND_DEBYE = 2'd2;

    // table word select codes
    localparam logic [3:0] SEL_TYPE = 4'd0;
    localparam logic [3:0] SEL_LAST = 4'd10;

    // coefficient slots in a table row
    localparam int K_CA   = 0;
    localparam int K_CBX  = 1;
    localparam int K_CBY  = 2;
    localparam int K_CBZ  = 3;
    localparam int K_V    = 4;
    localparam int K_W    = 5;
    localparam int K_RINV = 6;
    localparam int K_A    = 7;
    localparam int K_B    = 8;
    localparam int K_C    = 9;

    // 1.0 in Q4.28
    localparam logic signed [32:0] Q_ONE = 33'sh010000000;

    typedef struct packed {
        logic              command;
        logic [1:0]        axis;
        logic [11:0]       cell_index;
        logic [3:0]        material;
        logic [3:0]        coef_select;
        logic signed [31:0] coef_value;
        logic signed [31:0] e_old;
        logic signed [31:0] curl_first;
        logic signed [31:0] curl_second;
    } fdtd_in_t;

    typedef struct packed {
        logic signed [31:0] e_new;
        logic               saturated;
    } fdtd_out_t;

    typedef logic [NCOEF-1:0][31:0] coef_row_t;

    typedef struct packed {
        logic flag;
        logic signed [31:0] val;
    } sat_t;

    // write-back request from the datapath to the cell store
    typedef struct packed {
        logic               flux_en;
        logic               polar_en;
        logic signed [31:0] flux;
        logic signed [31:0] polar_last;
        logic signed [31:0] polar_before;
    } fdtd_wb_t;

    // round Q.44 product to Q.16: add half, floor shift by 28
    function automatic logic signed [37:0] rnd(input logic signed [65:0] p);
        logic signed [65:0] t;
        t = p + 66'sd134217728;
        return t[65:28];
    endfunction

    // clip to 32 bits and flag
    function automatic sat_t sat32(input logic signed [39:0] v);
        sat_t r;
        if (v > 40'sd2147483647) begin
            r.flag = 1'b1;
            r.val  = 32'sh7fffffff;
        end
        else if (v < -40'sd2147483648) begin
            r.flag = 1'b1;
            r.val  = 32'sh80000000;
        end
        else begin
            r.flag = 1'b0;
            r.val  = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/fdtd_dispersive_e_cell_update.sv -----
`timescale 1ns / 1ps
// Dispersive E-field cell update (plain, Drude and Debye materials).
// Input channel item/item_valid/item_stall: one beat is either an update of
// one E component of one cell or a write of one material table word.
// Output channel result/result_valid/result_stall: one beat per update whose
// axis and cell index are in range; table writes and out-of-range updates
// give no beat. Results leave in the order the updates were taken.
// A result passes the input register, six stages starting with the table/store
// read, and the output register before it becomes valid.
// Throughput: one beat per cycle unless stalled. An update to the same cell and
// axis as one still in the pipeline waits until that one has written its state
// back; repeated hits on one cell thus pass through the pipeline one at a time.
// Reset: material kinds return to plain; the per-cell D and polarization
// stores are then zeroed by a sweep over all 3*CELLS entries (12288 by default),
// during which item_stall is high.
// A stall on the output freezes the whole pipeline and raises item_stall;
// nothing is lost or repeated.
`include "assert_macros.svh"
module fdtd_dispersive_e_cell_update
    import fdtd_pkg::*;
#(
    parameter int CELLS     = CELLS_DEF,
    parameter int MATERIALS = MATERIALS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  fdtd_in_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output fdtd_out_t result
);

    localparam int SAW = $clog2(3 * CELLS);

    logic           adv;
    logic           accept;
    logic           upd_ok;
    logic           hit;
    logic           dp_hit;
    logic           clearing;
    logic [SAW-1:0] in_addr;

    // input register
    logic               s0_valid_reg;
    logic [SAW-1:0]     s0_addr_reg;
    logic [1:0]         s0_axis_reg;
    logic [3:0]         s0_mat_reg;
    logic signed [31:0] s0_e_old_reg, s0_c1_reg, s0_c2_reg;

    // output register
    logic      result_valid_reg;
    fdtd_out_t result_reg;

    coef_row_t          coef_q;
    logic [1:0]         kind_q;
    logic signed [31:0] flux_q, plast_q, pbefore_q;
    logic               res_valid;
    fdtd_out_t          res;
    fdtd_wb_t           wb;
    logic [SAW-1:0]     wb_addr;

    // address of the incoming update
    always_comb
    begin
        case (item.axis)
            AXIS_X:  in_addr = SAW'(32'(item.cell_index));
            AXIS_Y:  in_addr = SAW'(32'(item.cell_index) + CELLS);
            default: in_addr = SAW'(32'(item.cell_index) + 2 * CELLS);
        endcase
    end

    assign upd_ok = (item.command == CMD_UPDATE) && (item.axis != AXIS_NONE)
                  && (32'(item.cell_index) < CELLS);

    // pipeline moves when the output slot is free or being taken
    assign adv        = !result_valid_reg || !result_stall;
    assign hit        = upd_ok && ((s0_valid_reg && s0_addr_reg == in_addr) || dp_hit);
    assign item_stall = clearing || !adv || hit;
    assign accept     = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg     <= accept && upd_ok;
            result_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_addr_reg  <= in_addr;
            s0_axis_reg  <= item.axis;
            s0_mat_reg   <= item.material;
            s0_e_old_reg <= item.e_old;
            s0_c1_reg    <= item.curl_first;
            s0_c2_reg    <= item.curl_second;
            result_reg   <= res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // material table: written straight from a taken write beat
    fdtd_mat_table #(
        .MATERIALS (MATERIALS)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept && item.command == CMD_WRITE),
        .wr_mat   (item.material),
        .wr_sel   (item.coef_select),
        .wr_value (item.coef_value),
        .rd_en    (adv),
        .rd_mat   (s0_mat_reg),
        .row_q    (coef_q),
        .kind_q   (kind_q)
    );

    fdtd_cell_store #(
        .CELLS (CELLS)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .clearing  (clearing),
        .rd_en     (adv),
        .rd_addr   (s0_addr_reg),
        .flux_q    (flux_q),
        .plast_q   (plast_q),
        .pbefore_q (pbefore_q),
        .wb        (wb),
        .wb_addr   (wb_addr)
    );

    fdtd_datapath #(
        .CELLS (CELLS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s0_valid_reg),
        .in_addr   (s0_addr_reg),
        .in_axis   (s0_axis_reg),
        .in_e_old  (s0_e_old_reg),
        .in_c1     (s0_c1_reg),
        .in_c2     (s0_c2_reg),
        .kind_q    (kind_q),
        .coef_q    (coef_q),
        .flux_q    (flux_q),
        .plast_q   (plast_q),
        .pbefore_q (pbefore_q),
        .q_addr    (in_addr),
        .q_hit     (dp_hit),
        .res_valid (res_valid),
        .res       (res),
        .wb        (wb),
        .wb_addr   (wb_addr)
    );

    // no beat is taken during the reset sweep
    `ASSERT_IMPLIES(a_no_take_while_clearing, clk, rst_n, clearing, !accept)
    // state is written back only when the pipeline moves
    `ASSERT_IMPLIES(a_wb_on_adv, clk, rst_n, wb.flux_en || wb.polar_en, adv && !clearing)
    // a table write never enters the compute pipeline
    `ASSERT_NEXT(a_write_no_result, clk, rst_n, accept && item.command == CMD_WRITE,
                 !s0_valid_reg)

endmodule

// ----- rtl/fdtd_mat_table.sv -----
`timescale 1ns / 1ps
module fdtd_mat_table
    import fdtd_pkg::*;
#(
    parameter int MATERIALS = MATERIALS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [3:0]        wr_mat,
    input  logic [3:0]        wr_sel,
    input  logic signed [31:0] wr_value,
    input  logic              rd_en,
    input  logic [3:0]        rd_mat,
    output coef_row_t         row_q,
    output logic [1:0]        kind_q
);

    localparam int MAW = (MATERIALS > 1) ? $clog2(MATERIALS) : 1;

    logic [1:0] kind_reg [MATERIALS];
    coef_row_t  coef_mem [MATERIALS];

    logic           wr_ok;
    logic           rd_ok;
    logic [MAW-1:0] wr_a;
    logic [MAW-1:0] rd_a;

    assign wr_ok = wr_en && (32'(wr_mat) < MATERIALS) && (wr_sel <= SEL_LAST);
    assign rd_ok = 32'(rd_mat) < MATERIALS;
    assign wr_a  = MAW'(wr_mat);
    assign rd_a  = MAW'(rd_mat);

    // kind per material, plain after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MATERIALS; i++)
            begin
                kind_reg[i] <= KIND_PLAIN;
            end
        end
        else if (wr_ok && wr_sel == SEL_TYPE)
        begin
            kind_reg[wr_a] <= wr_value[1:0];
        end
    end

    // coefficient rows: one word written, one row read
    always_ff @(posedge clk)
    begin
        if (wr_ok && wr_sel != SEL_TYPE)
        begin
            coef_mem[wr_a][4'(wr_sel - 4'd1)] <= wr_value;
        end
        if (rd_en)
        begin
            row_q  <= rd_ok ? coef_mem[rd_a] : '0;
            kind_q <= rd_ok ? kind_reg[rd_a] : KIND_PLAIN;
        end
    end

endmodule

// ----- rtl/fdtd_cell_store.sv -----
`timescale 1ns / 1ps
module fdtd_cell_store
    import fdtd_pkg::*;
#(
    parameter int CELLS = CELLS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    output logic                                clearing,
    input  logic                                rd_en,
    input  logic [$clog2(3*CELLS)-1:0]          rd_addr,
    output logic signed [31:0]                  flux_q,
    output logic signed [31:0]                  plast_q,
    output logic signed [31:0]                  pbefore_q,
    input  fdtd_wb_t                            wb,
    input  logic [$clog2(3*CELLS)-1:0]          wb_addr
);

    localparam int DEPTH = 3 * CELLS;
    localparam int SAW   = $clog2(DEPTH);

    logic signed [31:0] flux_mem    [DEPTH];
    logic signed [31:0] plast_mem   [DEPTH];
    logic signed [31:0] pbefore_mem [DEPTH];

    logic           clearing_reg;
    logic [SAW-1:0] clr_cnt_reg;

    assign clearing = clearing_reg;

    // zero sweep after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == SAW'(DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            flux_mem[clr_cnt_reg]    <= '0;
            plast_mem[clr_cnt_reg]   <= '0;
            pbefore_mem[clr_cnt_reg] <= '0;
        end
        else
        begin
            if (wb.flux_en)
            begin
                flux_mem[wb_addr] <= wb.flux;
            end
            if (wb.polar_en)
            begin
                plast_mem[wb_addr]   <= wb.polar_last;
                pbefore_mem[wb_addr] <= wb.polar_before;
            end
        end
        if (rd_en)
        begin
            flux_q    <= flux_mem[rd_addr];
            plast_q   <= plast_mem[rd_addr];
            pbefore_q <= pbefore_mem[rd_addr];
        end
    end

endmodule

// ----- rtl/fdtd_datapath.sv -----
`timescale 1ns / 1ps
module fdtd_datapath
    import fdtd_pkg::*;
#(
    parameter int CELLS = CELLS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic                       in_valid,
    input  logic [$clog2(3*CELLS)-1:0] in_addr,
    input  logic [1:0]                 in_axis,
    input  logic signed [31:0]         in_e_old,
    input  logic signed [31:0]         in_c1,
    input  logic signed [31:0]         in_c2,
    input  logic [1:0]                 kind_q,
    input  coef_row_t                  coef_q,
    input  logic signed [31:0]         flux_q,
    input  logic signed [31:0]         plast_q,
    input  logic signed [31:0]         pbefore_q,
    input  logic [$clog2(3*CELLS)-1:0] q_addr,
    output logic                       q_hit,
    output logic                       res_valid,
    output fdtd_out_t                  res,
    output fdtd_wb_t                   wb,
    output logic [$clog2(3*CELLS)-1:0] wb_addr
);

    localparam int SAW = $clog2(3 * CELLS);

    // ---- stage valids and addresses ----
    logic           s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic           s4_valid_reg, s5_valid_reg, s6_valid_reg;
    logic [SAW-1:0] s1_addr_reg, s2_addr_reg, s3_addr_reg;
    logic [SAW-1:0] s4_addr_reg, s5_addr_reg, s6_addr_reg;
    logic [1:0]     s2_kind_reg, s3_kind_reg, s4_kind_reg, s5_kind_reg, s6_kind_reg;

    // stage 1 payload (table and store data arrive registered)
    logic [1:0]         s1_axis_reg;
    logic signed [31:0] s1_e_old_reg, s1_c1_reg, s1_c2_reg;

    // stage 2: products
    logic signed [63:0] s2_pca_reg, s2_p1_reg, s2_p2_reg, s2_pa_reg, s2_pc_reg, s2_ps2_reg;
    logic signed [64:0] s2_pk_reg, s2_ps1_reg;
    logic signed [31:0] s2_rinv_reg, s2_b_reg, s2_s1_reg;

    // stage 3: rounded sums
    logic signed [31:0] s3_d_reg, s3_k_reg, s3_rinv_reg, s3_b_reg, s3_s1_reg;
    logic               s3_dflag_reg, s3_kflag_reg;
    logic signed [39:0] s3_spart_reg;
    logic signed [37:0] s3_ra_reg, s3_rc_reg;

    // stage 4: second products
    logic signed [64:0] s4_pe_reg;
    logic signed [63:0] s4_pb_reg;
    logic signed [37:0] s4_ra_reg, s4_rc_reg;
    logic signed [31:0] s4_d_reg, s4_k_reg, s4_s1_reg;
    logic               s4_dflag_reg, s4_kflag_reg;
    logic signed [39:0] s4_spart_reg;

    // stage 5: E known
    logic signed [31:0] s5_e_reg, s5_k_reg, s5_d_reg, s5_s1_reg;
    logic               s5_flag_reg;
    logic signed [39:0] s5_spart_reg;

    // stage 6: k*E product
    logic signed [63:0] s6_pke_reg;
    logic signed [31:0] s6_e_reg, s6_d_reg, s6_s1_reg;
    logic               s6_flag_reg;
    logic signed [39:0] s6_spart_reg;

    // ---- stage 1 combinational: operand select and multiplies ----
    logic signed [31:0] cb1, cb2, ca_opnd;
    logic signed [32:0] omv, opv;
    logic               s1_stateful;

    always_comb
    begin
        case (s1_axis_reg)
            AXIS_X:
            begin
                cb1 = coef_q[K_CBY];
                cb2 = coef_q[K_CBZ];
            end
            AXIS_Y:
            begin
                cb1 = coef_q[K_CBZ];
                cb2 = coef_q[K_CBX];
            end
            default:
            begin
                cb1 = coef_q[K_CBX];
                cb2 = coef_q[K_CBY];
            end
        endcase
        s1_stateful = (kind_q == KIND_DRUDE) || (kind_q == KIND_DEBYE);
        ca_opnd     = s1_stateful ? flux_q : s1_e_old_reg;
        omv         = Q_ONE - 33'(signed'(coef_q[K_V]));
        opv         = Q_ONE + 33'(signed'(coef_q[K_V]));
    end

    // ---- stage 2 combinational: round and sum ----
    sat_t               s2_dsat, s2_ksat;
    logic signed [39:0] s2_spart;

    always_comb
    begin
        s2_dsat  = sat32(40'(rnd(66'(s2_pca_reg))) + 40'(rnd(66'(s2_p1_reg)))
                         + 40'(rnd(66'(s2_p2_reg))));
        s2_ksat  = sat32(40'(rnd(66'(s2_pk_reg))));
        s2_spart = 40'(rnd(66'(s2_ps1_reg))) - 40'(rnd(66'(s2_ps2_reg)));
    end

    // ---- stage 3 combinational: (D - S1) * rinv, B * D ----
    logic signed [32:0] s3_diff;

    assign s3_diff = 33'(s3_d_reg) - 33'(s3_s1_reg);

    // ---- stage 4 combinational: E per kind ----
    sat_t               s4_edr, s4_edb;
    logic signed [31:0] s4_e;
    logic               s4_flag;

    always_comb
    begin
        s4_edr = sat32(40'(rnd(66'(s4_pe_reg))));
        s4_edb = sat32(40'(s4_ra_reg) + 40'(rnd(66'(s4_pb_reg))) - 40'(s4_rc_reg));
        case (s4_kind_reg)
            KIND_DRUDE:
            begin
                s4_e    = s4_edr.val;
                s4_flag = s4_dflag_reg | s4_edr.flag | s4_kflag_reg;
            end
            KIND_DEBYE:
            begin
                s4_e    = s4_edb.val;
                s4_flag = s4_dflag_reg | s4_edb.flag;
            end
            default:
            begin
                s4_e    = s4_d_reg;
                s4_flag = s4_dflag_reg;
            end
        endcase
    end

    // ---- stage 6 combinational: polarization update and results ----
    sat_t s6_ssat;
    logic s6_drude, s6_debye;

    always_comb
    begin
        s6_ssat         = sat32(s6_spart_reg + 40'(rnd(66'(s6_pke_reg))));
        s6_drude        = s6_kind_reg == KIND_DRUDE;
        s6_debye        = s6_kind_reg == KIND_DEBYE;
        res_valid       = s6_valid_reg;
        res.e_new       = s6_e_reg;
        res.saturated   = s6_flag_reg | (s6_drude & s6_ssat.flag);
        wb.flux_en      = adv && s6_valid_reg && (s6_drude || s6_debye);
        wb.polar_en     = adv && s6_valid_reg && s6_drude;
        wb.flux         = s6_d_reg;
        wb.polar_last   = s6_ssat.val;
        wb.polar_before = s6_s1_reg;
        wb_addr         = s6_addr_reg;
    end

    // in-flight address match for read-after-write hazards
    assign q_hit = (s1_valid_reg && s1_addr_reg == q_addr)
                || (s2_valid_reg && s2_addr_reg == q_addr)
                || (s3_valid_reg && s3_addr_reg == q_addr)
                || (s4_valid_reg && s4_addr_reg == q_addr)
                || (s5_valid_reg && s5_addr_reg == q_addr)
                || (s6_valid_reg && s6_addr_reg == q_addr);

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    // payload chain
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // into stage 1
            s1_addr_reg  <= in_addr;
            s1_axis_reg  <= in_axis;
            s1_e_old_reg <= in_e_old;
            s1_c1_reg    <= in_c1;
            s1_c2_reg    <= in_c2;

            // into stage 2
            s2_addr_reg <= s1_addr_reg;
            s2_kind_reg <= kind_q;
            s2_pca_reg  <= signed'(coef_q[K_CA]) * ca_opnd;
            s2_p1_reg   <= cb1 * s1_c1_reg;
            s2_p2_reg   <= cb2 * s1_c2_reg;
            s2_pa_reg   <= signed'(coef_q[K_A]) * s1_e_old_reg;
            s2_pc_reg   <= signed'(coef_q[K_C]) * flux_q;
            s2_pk_reg   <= omv * signed'(coef_q[K_W]);
            s2_ps1_reg  <= opv * plast_q;
            s2_ps2_reg  <= signed'(coef_q[K_V]) * pbefore_q;
            s2_rinv_reg <= coef_q[K_RINV];
            s2_b_reg    <= coef_q[K_B];
            s2_s1_reg   <= plast_q;

            // into stage 3
            s3_addr_reg  <= s2_addr_reg;
            s3_kind_reg  <= s2_kind_reg;
            s3_d_reg     <= s2_dsat.val;
            s3_dflag_reg <= s2_dsat.flag;
            s3_k_reg     <= s2_ksat.val;
            s3_kflag_reg <= s2_ksat.flag;
            s3_spart_reg <= s2_spart;
            s3_ra_reg    <= rnd(66'(s2_pa_reg));
            s3_rc_reg    <= rnd(66'(s2_pc_reg));
            s3_rinv_reg  <= s2_rinv_reg;
            s3_b_reg     <= s2_b_reg;
            s3_s1_reg    <= s2_s1_reg;

            // into stage 4
            s4_addr_reg  <= s3_addr_reg;
            s4_kind_reg  <= s3_kind_reg;
            s4_pe_reg    <= s3_diff * s3_rinv_reg;
            s4_pb_reg    <= s3_b_reg * s3_d_reg;
            s4_ra_reg    <= s3_ra_reg;
            s4_rc_reg    <= s3_rc_reg;
            s4_d_reg     <= s3_d_reg;
            s4_dflag_reg <= s3_dflag_reg;
            s4_k_reg     <= s3_k_reg;
            s4_kflag_reg <= s3_kflag_reg;
            s4_spart_reg <= s3_spart_reg;
            s4_s1_reg    <= s3_s1_reg;

            // into stage 5
            s5_addr_reg  <= s4_addr_reg;
            s5_kind_reg  <= s4_kind_reg;
            s5_e_reg     <= s4_e;
            s5_flag_reg  <= s4_flag;
            s5_k_reg     <= s4_k_reg;
            s5_spart_reg <= s4_spart_reg;
            s5_d_reg     <= s4_d_reg;
            s5_s1_reg    <= s4_s1_reg;

            // into stage 6
            s6_addr_reg  <= s5_addr_reg;
            s6_kind_reg  <= s5_kind_reg;
            s6_pke_reg   <= s5_k_reg * s5_e_reg;
            s6_e_reg     <= s5_e_reg;
            s6_flag_reg  <= s5_flag_reg;
            s6_spart_reg <= s5_spart_reg;
            s6_d_reg     <= s5_d_reg;
            s6_s1_reg    <= s5_s1_reg;
        end
    end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
    import fdtd_pkg::*;

    localparam int CELLS     = CELLS_DEF;
    localparam int MATERIALS = MATERIALS_DEF;
    localparam int LIMIT     = 400000;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    fdtd_in_t  item;
    logic      result_valid;
    logic      result_stall;
    fdtd_out_t result;

    fdtd_dispersive_e_cell_update #(.CELLS(CELLS), .MATERIALS(MATERIALS)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result)
    );

    // Cell field predictor plus queue of pending E results.
    class e_field_scoreboard;
        logic signed [31:0] flux [3*CELLS];
        logic signed [31:0] s_last [3*CELLS];
        logic signed [31:0] s_prev [3*CELLS];
        logic [1:0]         kinds [MATERIALS];
        logic signed [31:0] coefs [MATERIALS][NCOEF];
        fdtd_out_t          pending [$];
        int                 mismatches;
        int                 checked;
        int                 updates;
        int                 writes;

        function new();
            foreach (flux[i]) begin
                flux[i] = 0;
                s_last[i] = 0;
                s_prev[i] = 0;
            end
            foreach (kinds[i]) kinds[i] = KIND_PLAIN;
            foreach (coefs[i, j]) coefs[i][j] = 0;
            mismatches = 0;
            checked = 0;
            updates = 0;
            writes = 0;
        endfunction

        // rounded Q.44 -> Q.16 product
        function automatic longint prod_round(longint a, longint b);
            longint p;
            p = a * b + (64'sd1 <<< 27);
            return p >>> 28;
        endfunction

        function automatic longint clip(longint v, ref bit f);
            if (v > 64'sd2147483647) begin
                f = 1;
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648) begin
                f = 1;
                return -64'sd2147483648;
            end
            return v;
        endfunction

        function void note_input(fdtd_in_t it);
            longint cf [NCOEF];
            longint cb1, cb2, d, d_old, e, s1, s2, v, k, s;
            logic [1:0] kd;
            bit f;
            int at;
            fdtd_out_t r;
            if (it.command == CMD_WRITE) begin
                writes++;
                if (it.material < MATERIALS && it.coef_select <= SEL_LAST) begin
                    if (it.coef_select == SEL_TYPE) kinds[it.material] = it.coef_value[1:0];
                    else coefs[it.material][it.coef_select-1] = it.coef_value;
                end
                return;
            end
            if (it.axis == AXIS_NONE || it.cell_index >= CELLS) return;
            updates++;
            kd = KIND_PLAIN;
            for (int i = 0; i < NCOEF; i++) cf[i] = 0;
            if (it.material < MATERIALS) begin
                kd = kinds[it.material];
                for (int i = 0; i < NCOEF; i++) cf[i] = coefs[it.material][i];
            end
            case (it.axis)
                AXIS_X:  begin cb1 = cf[K_CBY]; cb2 = cf[K_CBZ]; end
                AXIS_Y:  begin cb1 = cf[K_CBZ]; cb2 = cf[K_CBX]; end
                default: begin cb1 = cf[K_CBX]; cb2 = cf[K_CBY]; end
            endcase
            at = it.axis * CELLS + it.cell_index;
            d_old = flux[at];
            f = 0;
            if (kd == KIND_DRUDE) begin
                s1 = s_last[at];
                s2 = s_prev[at];
                v = cf[K_V];
                d = clip(prod_round(cf[K_CA], d_old) + prod_round(cb1, it.curl_first)
                         + prod_round(cb2, it.curl_second), f);
                e = clip(prod_round(d - s1, cf[K_RINV]), f);
                k = clip(prod_round((64'sd1 <<< 28) - v, cf[K_W]), f);
                s = clip(prod_round((64'sd1 <<< 28) + v, s1) - prod_round(v, s2)
                         + prod_round(k, e), f);
                s_prev[at] = s1;
                s_last[at] = s;
                flux[at] = d;
            end
            else if (kd == KIND_DEBYE) begin
                d = clip(prod_round(cf[K_CA], d_old) + prod_round(cb1, it.curl_first)
                         + prod_round(cb2, it.curl_second), f);
                e = clip(prod_round(cf[K_A], it.e_old) + prod_round(cf[K_B], d)
                         - prod_round(cf[K_C], d_old), f);
                flux[at] = d;
            end
            else begin
                e = clip(prod_round(cf[K_CA], it.e_old) + prod_round(cb1, it.curl_first)
                         + prod_round(cb2, it.curl_second), f);
            end
            r.e_new = e[31:0];
            r.saturated = f;
            pending.push_back(r);
        endfunction

        function void check_result(fdtd_out_t got);
            fdtd_out_t want;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat: e_new %h", got.e_new);
                return;
            end
            want = pending.pop_front();
            if (got.e_new !== want.e_new || got.saturated !== want.saturated) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: expected e_new %h sat %b, got e_new %h sat %b",
                             checked, want.e_new, want.saturated, got.e_new, got.saturated);
            end
        endfunction
    endclass

    e_field_scoreboard sb;
    longint cycles;
    int     out_gap;
    bit     all_sent;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** fdtd_dispersive_e_cell_update: FAILED **");
            $finish;
        end
    end

    // result side: check beats, random stall per beat
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall) sb.check_result(result);
    end

    always @(negedge clk)
    begin
        if (!rst_n) begin
            result_stall <= 1'b0;
            out_gap = 0;
        end
        else if (result_valid && !result_stall) begin
            out_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            result_stall <= (out_gap != 0);
        end
        else if (out_gap > 0) begin
            out_gap--;
            result_stall <= (out_gap != 0);
        end
        else result_stall <= 1'b0;
    end

    // present one beat and hold until taken, after a random gap;
    // valid stays high into the next beat when there is no gap
    task automatic send_beat(fdtd_in_t it, bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        do @(posedge clk); while (item_stall);
        sb.note_input(it);
        @(negedge clk);
    endtask

    task automatic write_word(logic [3:0] mat, logic [3:0] sel, logic [31:0] val);
        fdtd_in_t it;
        it = '0;
        it.command = CMD_WRITE;
        it.material = mat;
        it.coef_select = sel;
        it.coef_value = val;
        it.e_old = $urandom();
        it.curl_first = $urandom();
        it.curl_second = $urandom();
        it.axis = 2'($urandom());
        it.cell_index = 12'($urandom());
        send_beat(it, 0);
    endtask

    // wait for the pipeline to drain
    task automatic drain();
        item_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_coef(int mode);
        case (mode)
            0: return 32'h1000_0000 + $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
            1: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
            2: return $urandom();
            3: return 32'h7fff_ffff;
            default: return 32'h8000_0000;
        endcase
    endfunction

    // load every word of every row; modes 0 and 1 give gentle values, 2 mixes in wild ones, 3 extremes
    task automatic load_table(int mode);
        for (int m = 0; m < MATERIALS; m++) begin
            write_word(4'(m), SEL_TYPE, {30'($urandom_range(0, 1 << 29)), 2'(m % 4)});
            for (int s = 1; s <= SEL_LAST; s++) begin
                if (mode == 3) write_word(4'(m), 4'(s), (m % 2) ? 32'h7fff_ffff : 32'h8000_0000);
                else write_word(4'(m), 4'(s),
                                rand_coef((mode == 2 && $urandom_range(0, 3) == 0) ? 2 :
                                          ((s == 1) ? 0 : 1)));
            end
        end
    endtask

    function automatic fdtd_in_t rand_update(bit wild);
        fdtd_in_t it;
        it = '0;
        it.command = CMD_UPDATE;
        it.axis = ($urandom_range(0, 19) == 0) ? AXIS_NONE : 2'($urandom_range(0, 2));
        it.cell_index = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 7))
                                                    : 12'($urandom());
        it.material = 4'($urandom());
        it.coef_select = 4'($urandom());
        it.coef_value = $urandom();
        if (wild) begin
            it.e_old = $urandom();
            it.curl_first = $urandom();
            it.curl_second = $urandom();
        end
        else begin
            it.e_old = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
            it.curl_first = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            it.curl_second = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        end
        return it;
    endfunction

    initial
    begin
        fdtd_in_t it;
        sb = new();
        cycles = 0;
        clk = 1'b0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_stall = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // directed: load every table word first, so no update reads an unwritten word
        load_table(0);
        // ignored writes: select above ten
        write_word(4'd3, 4'd15, 32'hdead_beef);
        write_word(4'd5, 4'd11, 32'h1234_5678);
        // extremes of the input fields, every axis and kind
        for (int a = 0; a < 4; a++) begin
            it = rand_update(0);
            it.axis = 2'(a);
            it.cell_index = 12'hfff;
            it.material = 4'(a);
            it.e_old = 32'h7fff_ffff;
            it.curl_first = 32'h8000_0000;
            it.curl_second = 32'h7fff_ffff;
            send_beat(it, 0);
        end
        for (int m = 0; m < 4; m++) begin
            it = rand_update(0);
            it.axis = AXIS_Y;
            it.cell_index = 12'h000;
            it.material = 4'(m);
            it.e_old = 32'h8000_0000;
            it.curl_first = 32'h0;
            it.curl_second = 32'h8000_0000;
            send_beat(it, 1);
            send_beat(it, 1);
        end
        drain();

        // random phases over several table settings, extremes included
        for (int ph = 0; ph < 4; ph++) begin
            load_table(ph % 4);
            for (int n = 0; n < 265; n++) begin
                bit burst;
                burst = (n % 60) < 15;
                if ($urandom_range(0, 24) == 0)
                    write_word(4'($urandom()), 4'($urandom()), rand_coef(2));
                else
                    send_beat(rand_update(ph >= 2 && $urandom_range(0, 3) == 0), burst);
            end
            drain();
        end

        all_sent = 1;
        drain();
        $display("covered %0d updates and %0d table writes, %0d results checked",
                 sb.updates, sb.writes, sb.checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("** fdtd_dispersive_e_cell_update: PASSED **");
        else
            $display("** fdtd_dispersive_e_cell_update: FAILED **");
        $finish;
    end
endmodule

// ----- fdtd_dispersive_e_cell_update.f -----
+incdir+rtl
rtl/fdtd_pkg.sv
rtl/fdtd_mat_table.sv
rtl/fdtd_cell_store.sv
rtl/fdtd_datapath.sv
rtl/fdtd_dispersive_e_cell_update.sv
sim/testbench.sv
